// ===== sv/dep_pkg.sv =====
package dep_pkg;

   // Fixed field widths of the ports
   localparam int STAMP_IN_WIDTH = 16;
   localparam int HIGH_WIDTH     = 17;
   localparam int LOW_WIDTH      = 17;
   localparam int PERIOD_WIDTH   = 18;
   localparam int FREQ_WIDTH     = 32;

   typedef enum logic [1:0] {
      DEP_IDLE,
      DEP_DIVIDE,
      DEP_DELIVER
   } dep_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dep_div_status_type;

endpackage

// ===== sv/dep_divider.sv =====
module dep_divider import dep_pkg::*; #(
   parameter int DIVIDEND_WIDTH = 32,
   parameter int DIVISOR_WIDTH  = 18
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output dep_div_status_type        status,
   output logic [DIVIDEND_WIDTH-1:0] quotient
);

   localparam int CNT_WIDTH = (DIVIDEND_WIDTH > 2) ? $clog2(DIVIDEND_WIDTH) : 1;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_WIDTH-1:0]      count_ff, count_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH:0]    diff;
   logic                      take;

   // One restoring step per cycle on the shared subtractor
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
      take  = (trial >= {1'b0, divisor_ff});
      diff  = trial - {1'b0, divisor_ff};
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_WIDTH'(DIVIDEND_WIDTH - 1);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = take ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quo_in   = {quo_ff[DIVIDEND_WIDTH-2:0], take};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");

endmodule

// ===== sv/dual_edge_pulse_meter.sv =====
// Dual-edge pulse meter. Each transfer on the req_ channel is one edge of the
// measured signal, flagged rising or falling, with the timer count captured at
// that edge (low STAMP_WIDTH bits used, differences taken modulo
// 2^STAMP_WIDTH, equal stamps counted as one full rollover). The first edge
// after reset only records its stamp. A later falling edge updates the stored
// high time. A later rising edge yields one rsp_ transfer carrying high, low
// and period ticks and the frequency, csr_wr_data clock divided by period.
// A first or falling edge leaves req_ready high; an armed rising edge keeps
// req_ready low after its transfer while the bit-serial restoring divider runs
// (32 steps at one quotient bit per cycle), raises done and the result is
// handed off, so no further edge is taken until the sequencer is idle again.
// The result register lets the next edge be taken while a result waits, but
// a rising edge that finishes before the previous result is taken holds
// until rsp_ready. Write csr only while idle.
module dual_edge_pulse_meter import dep_pkg::*; #(
   parameter int STAMP_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_edge_falling,
   input  logic [STAMP_IN_WIDTH-1:0] req_stamp,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [HIGH_WIDTH-1:0]     rsp_high_ticks,
   output logic [LOW_WIDTH-1:0]      rsp_low_ticks,
   output logic [PERIOD_WIDTH-1:0]   rsp_period_ticks,
   output logic [FREQ_WIDTH-1:0]     rsp_frequency_hz,
   input  logic                      csr_wr_en,
   input  logic [FREQ_WIDTH-1:0]     csr_wr_data
);

   localparam int EXT_WIDTH  = (STAMP_WIDTH > STAMP_IN_WIDTH) ? STAMP_WIDTH : STAMP_IN_WIDTH;
   localparam int SPAN_WIDTH = STAMP_WIDTH + 1;
   localparam int PER_WIDTH  = STAMP_WIDTH + 2;

   dep_state_type state_ff, state_in;

   logic                     armed_ff, armed_in;
   logic [STAMP_WIDTH-1:0]   rise_ff, rise_in;
   logic [STAMP_WIDTH-1:0]   fall_ff, fall_in;
   logic [SPAN_WIDTH-1:0]    high_ff, high_in;
   logic [SPAN_WIDTH-1:0]    low_ff, low_in;
   logic [PER_WIDTH-1:0]     period_ff, period_in;
   logic [FREQ_WIDTH-1:0]    clk_hz_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [HIGH_WIDTH-1:0]    rsp_high_ff;
   logic [LOW_WIDTH-1:0]     rsp_low_ff;
   logic [PERIOD_WIDTH-1:0]  rsp_period_ff;
   logic [FREQ_WIDTH-1:0]    rsp_freq_ff;

   logic [EXT_WIDTH-1:0]     stamp_ext;
   logic [STAMP_WIDTH-1:0]   stamp;
   logic [STAMP_WIDTH-1:0]   diff_rise;
   logic [STAMP_WIDTH-1:0]   diff_fall;
   logic [SPAN_WIDTH-1:0]    span_rise;
   logic [SPAN_WIDTH-1:0]    span_fall;
   logic                     accept;
   logic                     div_start;
   logic                     out_load;
   logic                     out_free;
   dep_div_status_type       div_status;
   logic [FREQ_WIDTH-1:0]    div_quotient;

   // Drop stamp bits above the timer width
   assign stamp_ext = EXT_WIDTH'(req_stamp);
   assign stamp     = stamp_ext[STAMP_WIDTH-1:0];

   // Modulo spans; a zero difference means a full rollover
   assign diff_rise = stamp - fall_ff;
   assign diff_fall = stamp - rise_ff;
   assign span_rise = {(diff_rise == '0), diff_rise};
   assign span_fall = {(diff_fall == '0), diff_fall};

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: next state and control strobes
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         DEP_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && armed_ff && !req_edge_falling) begin
               div_start = 1'b1;
               state_in  = DEP_DIVIDE;
            end
         end
         DEP_DIVIDE: begin
            if (div_status.done) begin
               state_in = DEP_DELIVER;
            end
         end
         DEP_DELIVER: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = DEP_IDLE;
            end
         end
         default: begin
            state_in = DEP_IDLE;
         end
      endcase
   end

   // Edge bookkeeping on each accepted transfer
   always_comb begin
      armed_in  = armed_ff;
      rise_in   = rise_ff;
      fall_in   = fall_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      period_in = period_ff;
      if (accept) begin
         armed_in = 1'b1;
         if (req_edge_falling) begin
            fall_in = stamp;
            if (armed_ff) begin
               high_in = span_fall;
            end
         end else begin
            rise_in = stamp;
            if (armed_ff) begin
               low_in    = span_rise;
               period_in = PER_WIDTH'(high_ff) + PER_WIDTH'(span_rise);
            end
         end
      end
   end

   // Hold the result until the consumer takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DEP_IDLE;
         armed_ff     <= 1'b0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         high_ff      <= '0;
         clk_hz_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            clk_hz_ff <= csr_wr_data;
         end
      end
      low_ff    <= low_in;
      period_ff <= period_in;
      if (out_load) begin
         rsp_high_ff   <= HIGH_WIDTH'(high_ff);
         rsp_low_ff    <= LOW_WIDTH'(low_ff);
         rsp_period_ff <= PERIOD_WIDTH'(period_ff);
         rsp_freq_ff   <= div_quotient;
      end
   end

   // Frequency = timer clock / period, one quotient bit per cycle
   dep_divider #(
      .DIVIDEND_WIDTH (FREQ_WIDTH),
      .DIVISOR_WIDTH  (PER_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clk_hz_ff),
      .divisor  (period_in),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_high_ticks   = rsp_high_ff;
   assign rsp_low_ticks    = rsp_low_ff;
   assign rsp_period_ticks = rsp_period_ff;
   assign rsp_frequency_hz = rsp_freq_ff;

   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == DEP_DELIVER))
      else $error("result raised outside delivery");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_ready)
      else $error("input ready while divider busy");

   a_rise_starts_div: assert property (@(posedge clock) disable iff (reset)
      (accept && armed_ff && !req_edge_falling) |=> state_ff == DEP_DIVIDE)
      else $error("armed rising edge did not start a divide");

endmodule
